// File: sv/acpu_pkg.sv
`default_nettype none
package acpu_pkg;

    localparam int ADDR_BITS = 16;
    localparam int DATA_BITS = 16;
    localparam int OP_BITS   = 8;

    // Opcode keys. Unary and I/O opcodes are matched with bit 0 cleared,
    // register opcodes with bits 0 and 3 cleared.
    localparam logic [OP_BITS-1:0] UN_MASK  = 8'hFE;
    localparam logic [OP_BITS-1:0] REG_MASK = 8'hF6;

    localparam logic [OP_BITS-1:0] OP_STOP  = 8'h00;
    localparam logic [OP_BITS-1:0] OP_NOT   = 8'h18;
    localparam logic [OP_BITS-1:0] OP_ASL   = 8'h1C;
    localparam logic [OP_BITS-1:0] OP_ASR   = 8'h1E;
    localparam logic [OP_BITS-1:0] OP_ROL   = 8'h20;
    localparam logic [OP_BITS-1:0] OP_ROR   = 8'h22;
    localparam logic [OP_BITS-1:0] OP_DECI  = 8'h30;
    localparam logic [OP_BITS-1:0] OP_DECO  = 8'h38;
    localparam logic [OP_BITS-1:0] OP_CHARI = 8'h48;
    localparam logic [OP_BITS-1:0] OP_CHARO = 8'h50;
    localparam logic [OP_BITS-1:0] OP_ADD   = 8'h70;
    localparam logic [OP_BITS-1:0] OP_SUB   = 8'h80;
    localparam logic [OP_BITS-1:0] OP_AND   = 8'h90;
    localparam logic [OP_BITS-1:0] OP_OR    = 8'hA0;
    localparam logic [OP_BITS-1:0] OP_LD    = 8'hC0;
    localparam logic [OP_BITS-1:0] OP_LDB   = 8'hD0;
    localparam logic [OP_BITS-1:0] OP_ST    = 8'hE0;
    localparam logic [OP_BITS-1:0] OP_STB   = 8'hF0;

    localparam int UN_SEL_BIT  = 0;
    localparam int REG_SEL_BIT = 3;

    typedef logic [DATA_BITS-1:0] t_word;
    typedef logic [ADDR_BITS-1:0] t_addr;

    typedef struct packed {
        t_word acc;
        t_word idx;
        logic  wr_en;
        t_word wr_data;
        logic  out_valid;
        t_word out_data;
        logic  bad;
    } t_exec;

endpackage
`default_nettype wire

// File: sv/acpu_ram.sv
`default_nettype none
module acpu_ram #(
    parameter int AW = 16,
    parameter int DW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr0,
    input  wire logic [AW-1:0] i_raddr1,
    output logic      [DW-1:0] o_rdata0,
    output logic      [DW-1:0] o_rdata1
);

    logic [DW-1:0] mem [2**AW];

    // read-first: a same-cycle write is not seen by the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata0 <= mem[i_raddr0];
            o_rdata1 <= mem[i_raddr1];
        end
    end

endmodule
`default_nettype wire

// File: sv/acpu_exec.sv
`default_nettype none
module acpu_exec (
    input  wire logic [acpu_pkg::OP_BITS-1:0] i_op,
    input  wire acpu_pkg::t_word              i_acc,
    input  wire acpu_pkg::t_word              i_idx,
    input  wire acpu_pkg::t_word              i_mem,
    input  wire acpu_pkg::t_word              i_opnd,
    output acpu_pkg::t_exec                   o_ex
);
    import acpu_pkg::*;

    logic [OP_BITS-1:0] key_un;
    logic [OP_BITS-1:0] key_reg;
    logic               un_idx;
    logic               reg_idx;
    t_word              un_src;
    t_word              reg_src;
    t_word              un_res;
    t_word              reg_res;

    assign key_un  = i_op & UN_MASK;
    assign key_reg = i_op & REG_MASK;
    assign un_idx  = i_op[UN_SEL_BIT];
    assign reg_idx = i_op[REG_SEL_BIT];
    assign un_src  = un_idx ? i_idx : i_acc;
    assign reg_src = reg_idx ? i_idx : i_acc;

    always_comb begin
        case (key_un)
            OP_NOT:  un_res = ~un_src;
            OP_ASL:  un_res = {un_src[DATA_BITS-2:0], 1'b0};
            OP_ASR:  un_res = {un_src[DATA_BITS-1], un_src[DATA_BITS-1:1]};
            OP_ROL:  un_res = {un_src[DATA_BITS-2:0], un_src[DATA_BITS-1]};
            default: un_res = {un_src[0], un_src[DATA_BITS-1:1]};
        endcase
    end

    always_comb begin
        case (key_reg)
            OP_ADD:  reg_res = reg_src + i_mem;
            OP_SUB:  reg_res = reg_src - i_mem;
            OP_AND:  reg_res = reg_src & i_opnd;
            OP_OR:   reg_res = reg_src | i_opnd;
            default: reg_res = i_mem;
        endcase
    end

    always_comb begin
        o_ex           = '0;
        o_ex.acc       = i_acc;
        o_ex.idx       = i_idx;
        if (i_op != OP_STOP) begin
            case (key_un)
                OP_NOT, OP_ASL, OP_ASR, OP_ROL, OP_ROR: begin
                    if (un_idx) begin
                        o_ex.idx = un_res;
                    end else begin
                        o_ex.acc = un_res;
                    end
                end
                OP_DECI: begin
                    o_ex.wr_en   = 1'b1;
                    o_ex.wr_data = i_opnd;
                end
                OP_DECO: begin
                    o_ex.out_valid = 1'b1;
                    o_ex.out_data  = i_mem;
                end
                OP_CHARI: begin
                    o_ex.wr_en   = 1'b1;
                    o_ex.wr_data = {8'h00, i_opnd[7:0]};
                end
                OP_CHARO: begin
                    o_ex.out_valid = 1'b1;
                    o_ex.out_data  = {8'h00, i_mem[7:0]};
                end
                default: begin
                    case (key_reg)
                        OP_ADD, OP_SUB, OP_AND, OP_OR, OP_LD: begin
                            if (reg_idx) begin
                                o_ex.idx = reg_res;
                            end else begin
                                o_ex.acc = reg_res;
                            end
                        end
                        OP_LDB: begin
                            o_ex.acc = {8'h00, i_mem[7:0]};
                        end
                        OP_ST: begin
                            o_ex.wr_en   = 1'b1;
                            o_ex.wr_data = reg_src;
                        end
                        OP_STB: begin
                            o_ex.wr_en   = 1'b1;
                            o_ex.wr_data = {8'h00, i_acc[7:0]};
                        end
                        default: begin
                            o_ex.bad = 1'b1;
                        end
                    endcase
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: sv/accumulator_cpu_execute.sv
// Accumulator CPU execute block: runs one instruction per input beat.
// Input channel: i_valid / o_ready carrying i_mode (specifier byte),
// i_address and i_operand_in. Output channel: o_valid / i_ready carrying
// the registers after the instruction, the fetched instruction word and
// the console output / bad opcode flags.
// Pipeline: the accept cycle issues two reads of the data memory (fetch at
// PC and operand at address); the execute stage then executes, writes memory
// back and loads the output register once that register is free.
// Throughput is one instruction per cycle while i_ready stays high; the
// single write port and the dual read port memory set that figure, with a
// store forwarded to a read issued in the same cycle.
// Reset: registers go to zero and a clearing pass writes zero to all
// 2^ADDR_BITS words, one per cycle, with o_ready low.
// Stall: when i_ready is low the output register holds; one more
// instruction can be taken and waits in the execute stage, then o_ready
// drops until the output beat is taken.
`default_nettype none
module accumulator_cpu_execute (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [acpu_pkg::OP_BITS-1:0] i_mode,
    input  wire logic [15:0]                  i_address,
    input  wire logic [15:0]                  i_operand_in,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic signed [15:0]                o_accumulator,
    output logic [15:0]                       o_index_value,
    output logic [15:0]                       o_program_counter,
    output logic [15:0]                       o_instruction_word,
    output logic                              o_out_valid,
    output logic [15:0]                       o_out_data,
    output logic                              o_bad_opcode
);
    import acpu_pkg::*;

    logic               r_clr;
    t_addr              r_clr_addr;
    logic               r_started;
    t_word              r_pc;
    t_word              r_acc;
    t_word              r_idx;

    logic               r_s1_valid;
    logic [OP_BITS-1:0] r_s1_op;
    t_addr              r_s1_addr;
    t_word              r_s1_opnd;
    t_word              r_s1_pc;
    logic               r_s1_fetch;
    logic               r_fw0_hit;
    logic               r_fw1_hit;
    t_word              r_fw0_data;
    t_word              r_fw1_data;

    logic               r_o_valid;

    logic               accept;
    logic               s1_go;
    logic               we;
    t_addr              waddr;
    t_word              wdata;
    t_addr              raddr0;
    t_addr              raddr1;
    t_word              rdata0;
    t_word              rdata1;
    t_word              fetch_word;
    t_word              mem_word;
    t_exec              ex;

    assign s1_go   = r_s1_valid && (!r_o_valid || i_ready);
    assign o_ready = !r_clr && (!r_s1_valid || s1_go);
    assign accept  = i_valid && o_ready;

    assign we     = r_clr || (s1_go && ex.wr_en);
    assign waddr  = r_clr ? r_clr_addr : r_s1_addr;
    assign wdata  = r_clr ? '0 : ex.wr_data;
    assign raddr0 = r_pc[ADDR_BITS-1:0];
    assign raddr1 = i_address[ADDR_BITS-1:0];

    acpu_ram #(
        .AW(ADDR_BITS),
        .DW(DATA_BITS)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_re     (accept),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (rdata0),
        .o_rdata1 (rdata1)
    );

    assign fetch_word = r_fw0_hit ? r_fw0_data : rdata0;
    assign mem_word   = r_fw1_hit ? r_fw1_data : rdata1;

    acpu_exec u_exec (
        .i_op   (r_s1_op),
        .i_acc  (r_acc),
        .i_idx  (r_idx),
        .i_mem  (mem_word),
        .i_opnd (r_s1_opnd),
        .o_ex   (ex)
    );

    // clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            if (&r_clr_addr) begin
                r_clr <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // issue stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= 1'b0;
            r_pc       <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_started  <= 1'b1;
                r_pc       <= r_pc + 1'b1;
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op    <= i_mode;
            r_s1_addr  <= raddr1;
            r_s1_opnd  <= i_operand_in;
            r_s1_pc    <= r_pc + 1'b1;
            r_s1_fetch <= r_started;
            // write in flight this cycle is missed by the read-first RAM
            r_fw0_hit  <= we && (waddr == raddr0);
            r_fw1_hit  <= we && (waddr == raddr1);
            r_fw0_data <= wdata;
            r_fw1_data <= wdata;
        end
    end

    // execute stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (s1_go) begin
                r_acc     <= ex.acc;
                r_idx     <= ex.idx;
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            o_accumulator      <= signed'(ex.acc);
            o_index_value      <= ex.idx;
            o_program_counter  <= r_s1_pc;
            o_instruction_word <= r_s1_fetch ? fetch_word : '0;
            o_out_valid        <= ex.out_valid;
            o_out_data         <= ex.out_data;
            o_bad_opcode       <= ex.bad;
        end
    end

    assign o_valid = r_o_valid;

endmodule
`default_nettype wire

// File: tb/acpu_checker.sv
`timescale 1ns / 100ps
module acpu_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic                         i_in_ready,
    input  wire logic [acpu_pkg::OP_BITS-1:0] i_mode,
    input  wire logic [15:0]                  i_address,
    input  wire logic [15:0]                  i_operand_in,
    input  wire logic                         i_res_valid,
    input  wire logic                         i_res_ready,
    input  wire logic [15:0]                  i_acc,
    input  wire logic [15:0]                  i_index,
    input  wire logic [15:0]                  i_pc,
    input  wire logic [15:0]                  i_ir,
    input  wire logic                         i_out_valid,
    input  wire logic [15:0]                  i_out_data,
    input  wire logic                         i_bad_opcode,
    output int                                o_fail_count,
    output int                                o_pending
);
    import acpu_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_word acc;
        t_word idx;
        t_word pc;
        t_word ir;
        logic  out_valid;
        t_word out_data;
        logic  bad;
    } t_cpu_state;

    // shadow copy of the CPU
    t_word      mem_model [0:(1 << ADDR_BITS) - 1];
    t_word      acc_q;
    t_word      idx_q;
    t_word      pc_q;
    t_word      ir_q;
    logic       started_q;
    t_cpu_state expected_q [$];

    task automatic run_instruction(input logic [OP_BITS-1:0] mode, input t_addr addr,
                                   input t_word opnd, output t_cpu_state res);
        t_word m;
        t_word r;
        logic  use_idx_un;
        logic  use_idx_reg;
        logic  reg_write;
        res = '0;
        if (started_q) begin
            ir_q = mem_model[pc_q];
        end else begin
            acc_q     = '0;
            idx_q     = '0;
            pc_q      = '0;
            ir_q      = '0;
            started_q = 1'b1;
        end
        pc_q        = pc_q + 16'd1;
        m           = mem_model[addr];
        use_idx_un  = mode[UN_SEL_BIT];
        use_idx_reg = mode[REG_SEL_BIT];
        if (mode != OP_STOP) begin
            case (mode & UN_MASK)
                OP_NOT, OP_ASL, OP_ASR, OP_ROL, OP_ROR: begin
                    r = use_idx_un ? idx_q : acc_q;
                    case (mode & UN_MASK)
                        OP_NOT:  r = ~r;
                        OP_ASL:  r = {r[14:0], 1'b0};
                        OP_ASR:  r = {r[15], r[15:1]};
                        OP_ROL:  r = {r[14:0], r[15]};
                        default: r = {r[0], r[15:1]};
                    endcase
                    if (use_idx_un) idx_q = r;
                    else acc_q = r;
                end
                OP_DECI: mem_model[addr] = opnd;
                OP_DECO: begin
                    res.out_valid = 1'b1;
                    res.out_data  = m;
                end
                OP_CHARI: mem_model[addr] = {8'h00, opnd[7:0]};
                OP_CHARO: begin
                    res.out_valid = 1'b1;
                    res.out_data  = {8'h00, m[7:0]};
                end
                default: begin
                    r         = use_idx_reg ? idx_q : acc_q;
                    reg_write = 1'b1;
                    case (mode & REG_MASK)
                        OP_ADD: r = r + m;
                        OP_SUB: r = r - m;
                        OP_AND: r = r & opnd;
                        OP_OR:  r = r | opnd;
                        OP_LD:  r = m;
                        OP_LDB: begin
                            // byte ops always target the accumulator
                            reg_write = 1'b0;
                            acc_q     = {8'h00, m[7:0]};
                        end
                        OP_ST: begin
                            reg_write       = 1'b0;
                            mem_model[addr] = r;
                        end
                        OP_STB: begin
                            reg_write       = 1'b0;
                            mem_model[addr] = {8'h00, acc_q[7:0]};
                        end
                        default: begin
                            reg_write = 1'b0;
                            res.bad   = 1'b1;
                        end
                    endcase
                    if (reg_write) begin
                        if (use_idx_reg) idx_q = r;
                        else acc_q = r;
                    end
                end
            endcase
        end
        res.acc = acc_q;
        res.idx = idx_q;
        res.pc  = pc_q;
        res.ir  = ir_q;
    endtask

    always @(posedge i_clk) begin
        t_cpu_state got;
        t_cpu_state want;
        if (!i_rst_n) begin
            foreach (mem_model[k]) mem_model[k] = '0;
            acc_q        = '0;
            idx_q        = '0;
            pc_q         = '0;
            ir_q         = '0;
            started_q    = 1'b0;
            o_fail_count = 0;
            expected_q.delete();
        end else begin
            // result side first: a beat taken this edge can't come out this edge
            if (i_res_valid && i_res_ready) begin
                got.acc       = i_acc;
                got.idx       = i_index;
                got.pc        = i_pc;
                got.ir        = i_ir;
                got.out_valid = i_out_valid;
                got.out_data  = i_out_data;
                got.bad       = i_bad_opcode;
                if (expected_q.size() == 0) begin
                    if (o_fail_count < REPORT_LIMIT)
                        $display("%0t: result beat with nothing outstanding", $time);
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < REPORT_LIMIT) begin
                            $display("%0t: exp acc=%h idx=%h pc=%h ir=%h ov=%b od=%h bad=%b",
                                     $time, want.acc, want.idx, want.pc, want.ir,
                                     want.out_valid, want.out_data, want.bad);
                            $display("%0t: got acc=%h idx=%h pc=%h ir=%h ov=%b od=%h bad=%b",
                                     $time, got.acc, got.idx, got.pc, got.ir,
                                     got.out_valid, got.out_data, got.bad);
                        end
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                run_instruction(i_mode, i_address, i_operand_in, want);
                expected_q.push_back(want);
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
    import acpu_pkg::*;

    localparam int ITEM_COUNT  = 900;
    localparam int CYCLE_LIMIT = 400_000;   // includes the memory clear
    localparam int HOLD_CYCLES = 150;
    localparam int TAIL_CYCLES = 8;

    localparam logic [OP_BITS-1:0] UN_X         = OP_BITS'(1) << UN_SEL_BIT;
    localparam logic [OP_BITS-1:0] REG_X        = OP_BITS'(1) << REG_SEL_BIT;
    localparam logic [OP_BITS-1:0] BAD_STOP_SEL = OP_STOP | UN_X;
    localparam logic [OP_BITS-1:0] BAD_ALL_ONES = 8'hFF;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [OP_BITS-1:0] i_mode;
    t_addr              i_address;
    t_word              i_operand_in;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_accumulator;
    logic [15:0]        o_index_value;
    logic [15:0]        o_program_counter;
    logic [15:0]        o_instruction_word;
    logic               o_out_valid;
    logic [15:0]        o_out_data;
    logic               o_bad_opcode;

    int    fail_count;
    int    pending;
    int    beats_sent = 0;
    int    beats_out  = 0;
    t_addr last_addr  = '0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    accumulator_cpu_execute dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_mode             (i_mode),
        .i_address          (i_address),
        .i_operand_in       (i_operand_in),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_accumulator      (o_accumulator),
        .o_index_value      (o_index_value),
        .o_program_counter  (o_program_counter),
        .o_instruction_word (o_instruction_word),
        .o_out_valid        (o_out_valid),
        .o_out_data         (o_out_data),
        .o_bad_opcode       (o_bad_opcode)
    );

    acpu_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_mode       (i_mode),
        .i_address    (i_address),
        .i_operand_in (i_operand_in),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_acc        (o_accumulator),
        .i_index      (o_index_value),
        .i_pc         (o_program_counter),
        .i_ir         (o_instruction_word),
        .i_out_valid  (o_out_valid),
        .i_out_data   (o_out_data),
        .i_bad_opcode (o_bad_opcode),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) beats_out <= beats_out + 1;
    end

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input logic [OP_BITS-1:0] mode, input t_addr addr,
                             input t_word opnd);
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_address    <= addr;
        i_operand_in <= opnd;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        beats_sent++;
    endtask

    task automatic make_instruction(output logic [OP_BITS-1:0] mode, output t_addr addr,
                                    output t_word opnd);
        logic [OP_BITS-1:0] sel_un;
        logic [OP_BITS-1:0] sel_reg;
        int                 pick;
        sel_un  = OP_BITS'($urandom_range(0, 1)) << UN_SEL_BIT;
        sel_reg = sel_un | (OP_BITS'($urandom_range(0, 1)) << REG_SEL_BIT);
        case ($urandom_range(0, 19))
            0:       mode = OP_STOP;
            1:       mode = OP_NOT | sel_un;
            2:       mode = OP_ASL | sel_un;
            3:       mode = OP_ASR | sel_un;
            4:       mode = OP_ROL | sel_un;
            5:       mode = OP_ROR | sel_un;
            6:       mode = OP_DECI | sel_un;
            7:       mode = OP_DECO | sel_un;
            8:       mode = OP_CHARI | sel_un;
            9:       mode = OP_CHARO | sel_un;
            10:      mode = OP_ADD | sel_reg;
            11:      mode = OP_SUB | sel_reg;
            12:      mode = OP_AND | sel_reg;
            13:      mode = OP_OR | sel_reg;
            14:      mode = OP_LD | sel_reg;
            15:      mode = OP_LDB | sel_reg;
            16:      mode = OP_ST | sel_reg;
            17:      mode = OP_STB | sel_reg;
            default: mode = OP_BITS'($urandom);   // mostly illegal specifiers
        endcase
        // aim stores just ahead of the PC so later fetches see them,
        // and reuse the last address to exercise store-to-load forwarding
        pick = $urandom_range(0, 99);
        if (pick < 35)      addr = t_addr'(beats_sent + $urandom_range(0, 12));
        else if (pick < 55) addr = last_addr;
        else if (pick < 80) addr = t_addr'($urandom_range(0, 31));
        else                addr = t_addr'($urandom);
        last_addr = addr;
        case ($urandom_range(0, 7))
            0:       opnd = 16'h0000;
            1:       opnd = 16'hFFFF;
            2:       opnd = 16'h8000;
            3:       opnd = 16'h7FFF;
            4:       opnd = 16'h00FF;
            default: opnd = t_word'($urandom);
        endcase
    endtask

    // receiver: changing stall styles plus long hold-offs to back the block up
    initial begin
        int hold_left;
        int next_hold;
        int phase_left;
        int style;
        int run_left;
        logic run_val;
        hold_left  = 0;
        next_hold  = 250;
        phase_left = 0;
        style      = 0;
        run_left   = 0;
        run_val    = 1'b1;
        i_ready    <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (beats_out >= next_hold) begin
                hold_left = HOLD_CYCLES - 1;
                next_hold += 400;
                i_ready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    style      = $urandom_range(0, 3);
                    phase_left = $urandom_range(20, 100);
                end
                phase_left--;
                case (style)
                    0: i_ready <= 1'b1;
                    1: i_ready <= 1'($urandom_range(0, 1));
                    2: i_ready <= ($urandom_range(0, 9) != 0);
                    default: begin
                        if (run_left == 0) begin
                            run_val  = !run_val;
                            run_left = $urandom_range(1, 6);
                        end
                        run_left--;
                        i_ready <= run_val;
                    end
                endcase
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [OP_BITS-1:0] mode;
        t_addr              addr;
        t_word              opnd;
        int                 burst_left;
        int                 gap;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_mode       <= '0;
        i_address    <= '0;
        i_operand_in <= '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: first-step zeroing, every operation, some on both registers,
        // field extremes, stop and illegal specifiers
        send_beat(OP_DECI, 16'h0001, 16'hFFFF);
        send_beat(OP_LD, 16'h0001, 16'h0000);
        send_beat(OP_NOT | UN_X, 16'h0000, 16'h0000);
        send_beat(OP_ASR, 16'hFFFF, 16'hFFFF);
        send_beat(OP_DECI | UN_X, 16'hFFFF, 16'h8001);
        send_beat(OP_ADD | REG_X, 16'hFFFF, 16'h0000);
        send_beat(OP_LD | UN_X, 16'hFFFF, 16'h0000);
        send_beat(OP_ROL, 16'h0000, 16'h0000);
        send_beat(OP_ROR | UN_X, 16'h0000, 16'h0000);
        send_beat(OP_ASR | UN_X, 16'h0000, 16'h0000);
        send_beat(OP_ASL | UN_X, 16'h0000, 16'h0000);
        send_beat(OP_ROR, 16'h0000, 16'h0000);
        send_beat(OP_ASL, 16'h0000, 16'h0000);
        send_beat(OP_SUB, 16'h0001, 16'h0000);
        send_beat(OP_SUB | REG_X | UN_X, 16'hFFFF, 16'h0000);
        send_beat(OP_AND | REG_X, 16'h0000, 16'h0F0F);
        send_beat(OP_OR, 16'h0000, 16'hF000);
        send_beat(OP_LDB | REG_X, 16'hFFFF, 16'h0000);
        send_beat(OP_CHARI | UN_X, 16'h0011, 16'hABCD);
        send_beat(OP_CHARO | UN_X, 16'h0011, 16'h0000);
        send_beat(OP_DECO, 16'hFFFF, 16'h0000);
        send_beat(OP_STB | REG_X | UN_X, 16'h0018, 16'h0000);
        send_beat(OP_ST | REG_X, 16'h0019, 16'h0000);
        send_beat(OP_ST, 16'h001A, 16'h0000);
        send_beat(OP_STOP, 16'hFFFF, 16'hFFFF);
        send_beat(BAD_STOP_SEL, 16'h0000, 16'h0000);
        send_beat(BAD_ALL_ONES, 16'hFFFF, 16'hFFFF);
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);

        burst_left = 0;
        for (int n = 0; n < ITEM_COUNT; n++) begin
            if (n == ITEM_COUNT / 2) begin
                // let the pipe run dry once
                i_valid <= 1'b0;
                do @(negedge i_clk); while (pending != 0);
            end
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            make_instruction(mode, addr, opnd);
            send_beat(mode, addr, opnd);
            burst_left--;
        end
        i_valid <= 1'b0;

        do @(negedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: accumulator_cpu_execute.f
sv/acpu_pkg.sv
sv/acpu_ram.sv
sv/acpu_exec.sv
sv/accumulator_cpu_execute.sv
tb/acpu_checker.sv
tb/testbench.sv
